@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the I2C master bit engine.
// Each macro checks on the rising edge of clock and is off while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Overlapping implication: the consequent must hold on the same edge.
`define ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Non-overlapping implication: the consequent must hold on the next edge.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/i2cm_pkg.sv @@
// ----------------------------------------------------------------------------
// i2cm_pkg
// Operation codes, internal command codes and line tables for the I2C master
// bit engine.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cm_pkg;

   typedef logic [2:0] op_type;
   typedef logic [2:0] cmd_type;

   // Operation codes carried by an input item.
   localparam op_type OP_TICK  = 3'd0;
   localparam op_type OP_START = 3'd1;
   localparam op_type OP_WRITE = 3'd2;
   localparam op_type OP_READ  = 3'd3;
   localparam op_type OP_STOP  = 3'd4;

   // Internal command codes; the address phase of a start has its own code.
   localparam cmd_type CMD_IDLE  = 3'd0;
   localparam cmd_type CMD_START = 3'd1;
   localparam cmd_type CMD_WRITE = 3'd2;
   localparam cmd_type CMD_READ  = 3'd3;
   localparam cmd_type CMD_STOP  = 3'd4;
   localparam cmd_type CMD_ADDR  = 3'd5;

   localparam logic [7:0] ACK_POLL_LIMIT_RESET = 8'd10;
   localparam logic [2:0] BIT_INDEX_RESET      = 3'd7;

   // Start condition line levels, one entry per step.
   localparam logic [3:0] START_SCL = 4'b0110;  // step 3 down to step 0
   localparam logic [3:0] START_SDA = 4'b0011;

endpackage

`default_nettype wire

@@ rtl/core/i2c_master_bit_engine.sv @@
// ----------------------------------------------------------------------------
// i2c_master_bit_engine
// I2C master sequencer: each tick item drives one SCL/SDA step and supplies
// one sampled SDA bit; start, write, read and stop commands are taken while idle.
// ----------------------------------------------------------------------------
//
//   Port group   Direction   Handshake                Content
//   req_*        in          req_valid / req_stall    operation, byte, last, SDA sample
//   rsp_*        out         rsp_valid / rsp_stall    line levels, busy, done, status, byte
//   csr_*        in          csr_write_enable         acknowledge poll limit
//
// Every item yields one result in the cycle after it is accepted; an item can be accepted
// every cycle while no held result is stalled. The sequencer state and the result are
// updated on the accept edge by a single pass of logic, and the result register then holds
// it. While a result waits under rsp_stall, req_stall is raised; it drops in the cycle the
// result is taken, so a new item enters as the old one leaves. Synchronous reset idles the
// sequencer and releases the internal lines; the result payload register is not reset.
`default_nettype none

`include "assert_macros.svh"

module i2c_master_bit_engine (
   input  wire                   clock,
   input  wire                   reset,

   input  wire                   req_valid,
   output logic                  req_stall,
   input  wire i2cm_pkg::op_type req_operation,
   input  wire  [7:0]            req_data_byte,
   input  wire                   req_last_byte,
   input  wire                   req_sda_sample,

   output logic                  rsp_valid,
   input  wire                   rsp_stall,
   output logic                  rsp_scl_level,
   output logic                  rsp_sda_level,
   output logic                  rsp_busy_res,
   output logic                  rsp_done_res,
   output logic                  rsp_status,
   output logic [7:0]            rsp_read_byte,

   input  wire                   csr_write_enable,
   input  wire  [7:0]            csr_write_data
);

   import i2cm_pkg::*;

   logic [7:0] limit_ff;

   cmd_type    command_ff, command_in;
   logic [2:0] step_ff, step_in;
   logic [2:0] bit_ff, bit_in;
   logic [7:0] shift_ff, shift_in;
   logic [7:0] poll_ff, poll_in;
   logic       nack_ff, nack_in;
   logic       scl_ff, scl_in;
   logic       sda_ff, sda_in;

   logic       done_in;
   logic       status_in;
   logic [7:0] rbyte_in;
   logic       data_bit;

   logic       rsp_valid_ff, rsp_valid_in;
   logic       scl_out_ff, sda_out_ff, busy_out_ff, done_out_ff, status_out_ff;
   logic [7:0] rbyte_out_ff;

   logic       accept;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   // Next sequencer state for the item at the input.
   always_comb begin
      command_in = command_ff;
      step_in    = step_ff;
      bit_in     = bit_ff;
      shift_in   = shift_ff;
      poll_in    = poll_ff;
      nack_in    = nack_ff;
      scl_in     = scl_ff;
      sda_in     = sda_ff;
      done_in    = 1'b0;
      status_in  = 1'b0;
      rbyte_in   = 8'd0;

      if (command_ff == CMD_IDLE && (req_operation inside {[OP_START:OP_STOP]})) begin
         command_in = req_operation;
         step_in    = 3'd0;
         bit_in     = BIT_INDEX_RESET;
         poll_in    = 8'd0;
         nack_in    = 1'b0;
         if (req_operation == OP_START || req_operation == OP_WRITE) begin
            shift_in = req_data_byte;
         end else if (req_operation == OP_READ) begin
            shift_in = 8'd0;
            nack_in  = req_last_byte;
         end
      end

      data_bit = shift_in[bit_in];

      case (command_in)
         CMD_START: begin
            scl_in = START_SCL[step_in[1:0]];
            sda_in = START_SDA[step_in[1:0]];
            if (step_in >= 3'd3) begin
               command_in = CMD_ADDR;
               step_in    = 3'd0;
            end else begin
               step_in = step_in + 3'd1;
            end
         end
         CMD_WRITE, CMD_ADDR: begin
            case (step_in)
               3'd0: begin
                  scl_in = 1'b0; sda_in = 1'b0; step_in = 3'd1;
               end
               3'd1: begin
                  scl_in = 1'b0; sda_in = data_bit; step_in = 3'd2;
               end
               3'd2: begin
                  scl_in = 1'b1; sda_in = data_bit; step_in = 3'd3;
               end
               3'd3: begin
                  scl_in = 1'b0;
                  sda_in = data_bit;
                  if (bit_in == 3'd0) begin
                     step_in = 3'd4;
                  end else begin
                     bit_in  = bit_in - 3'd1;
                     step_in = 3'd1;
                  end
               end
               3'd4: begin
                  scl_in = 1'b0; sda_in = 1'b1; step_in = 3'd5;
               end
               3'd5, 3'd6: begin
                  // Acknowledge polling holds SCL high until SDA goes low
                  // or the poll limit is used up.
                  scl_in = 1'b1;
                  sda_in = 1'b1;
                  if (step_in == 3'd5) begin
                     poll_in = 8'd0;
                  end
                  if (!req_sda_sample) begin
                     nack_in = 1'b0;
                     step_in = 3'd7;
                  end else if (poll_in >= limit_ff) begin
                     nack_in = 1'b1;
                     step_in = 3'd7;
                  end else begin
                     poll_in = poll_in + 8'd1;
                     step_in = 3'd6;
                  end
               end
               default: begin
                  scl_in = 1'b0;
                  sda_in = 1'b1;
                  if (command_in == CMD_ADDR && nack_in) begin
                     // An address without acknowledge ends in a stop.
                     command_in = CMD_STOP;
                     step_in    = 3'd0;
                  end else begin
                     done_in    = 1'b1;
                     status_in  = nack_in;
                     command_in = CMD_IDLE;
                     step_in    = 3'd0;
                     bit_in     = BIT_INDEX_RESET;
                     nack_in    = 1'b0;
                  end
               end
            endcase
         end
         CMD_READ: begin
            case (step_in)
               3'd0: begin
                  scl_in = 1'b0; sda_in = 1'b1; step_in = 3'd1;
               end
               3'd1: begin
                  scl_in = 1'b1;
                  sda_in = 1'b1;
                  if (req_sda_sample) begin
                     shift_in[bit_in] = 1'b1;
                  end
                  step_in = 3'd2;
               end
               3'd2: begin
                  scl_in = 1'b0;
                  sda_in = 1'b1;
                  if (bit_in == 3'd0) begin
                     step_in = 3'd3;
                  end else begin
                     bit_in  = bit_in - 3'd1;
                     step_in = 3'd1;
                  end
               end
               3'd3: begin
                  scl_in = 1'b0; sda_in = nack_in; step_in = 3'd4;
               end
               3'd4: begin
                  scl_in = 1'b1; sda_in = nack_in; step_in = 3'd5;
               end
               default: begin
                  scl_in     = 1'b0;
                  sda_in     = nack_in;
                  done_in    = 1'b1;
                  rbyte_in   = shift_in;
                  command_in = CMD_IDLE;
                  step_in    = 3'd0;
                  bit_in     = BIT_INDEX_RESET;
                  nack_in    = 1'b0;
               end
            endcase
         end
         CMD_STOP: begin
            if (step_in == 3'd0) begin
               scl_in = 1'b0; sda_in = 1'b0; step_in = 3'd1;
            end else if (step_in == 3'd1) begin
               scl_in = 1'b1; sda_in = 1'b0; step_in = 3'd2;
            end else begin
               scl_in     = 1'b1;
               sda_in     = 1'b1;
               done_in    = 1'b1;
               status_in  = nack_in;
               command_in = CMD_IDLE;
               step_in    = 3'd0;
               bit_in     = BIT_INDEX_RESET;
               nack_in    = 1'b0;
            end
         end
         CMD_IDLE: begin
         end
         default: begin
            command_in = CMD_IDLE;
            step_in    = 3'd0;
            bit_in     = BIT_INDEX_RESET;
            nack_in    = 1'b0;
         end
      endcase
   end

   always_comb begin
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= ACK_POLL_LIMIT_RESET;
         command_ff   <= CMD_IDLE;
         step_ff      <= 3'd0;
         bit_ff       <= BIT_INDEX_RESET;
         shift_ff     <= 8'd0;
         poll_ff      <= 8'd0;
         nack_ff      <= 1'b0;
         scl_ff       <= 1'b1;
         sda_ff       <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            limit_ff <= csr_write_data;
         end
         if (accept) begin
            command_ff <= command_in;
            step_ff    <= step_in;
            bit_ff     <= bit_in;
            shift_ff   <= shift_in;
            poll_ff    <= poll_in;
            nack_ff    <= nack_in;
            scl_ff     <= scl_in;
            sda_ff     <= sda_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload register, loaded with each accepted item.
   always_ff @(posedge clock) begin
      if (accept) begin
         scl_out_ff    <= scl_in;
         sda_out_ff    <= sda_in;
         busy_out_ff   <= (command_in != CMD_IDLE);
         done_out_ff   <= done_in;
         status_out_ff <= status_in;
         rbyte_out_ff  <= rbyte_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_scl_level = scl_out_ff;
   assign rsp_sda_level = sda_out_ff;
   assign rsp_busy_res  = busy_out_ff;
   assign rsp_done_res  = done_out_ff;
   assign rsp_status    = status_out_ff;
   assign rsp_read_byte = rbyte_out_ff;

   `ASSERT_IMPLY(a_stall_needs_result, req_stall, rsp_valid_ff, "input stalled with no result held")
   `ASSERT_NEXT(a_accept_gives_result, accept, rsp_valid_ff, "accepted item produced no result")
   `ASSERT_IMPLY(a_done_not_busy, rsp_valid_ff && rsp_done_res, !rsp_busy_res, "done while busy")
   `ASSERT_IMPLY(a_status_with_done, rsp_valid_ff && rsp_status, rsp_done_res, "status without done")

endmodule

`default_nettype wire

@@ bench/i2c_master_bit_engine_tb.sv @@
// ----------------------------------------------------------------------------
// i2c_master_bit_engine_tb
// Self-checking bench for the I2C master bit engine. Tick items are driven
// with random gaps while the result side stalls at random. A line-step model
// predicts the SCL/SDA levels, busy, done, status and read byte of every tick,
// and each result is checked against the oldest prediction. Well-formed
// transactions with random acknowledge timing are run under several poll
// limits, mixed with ignored codes and commands issued while busy.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine_tb;
   import i2cm_pkg::*;

   typedef struct packed {
      logic       scl;
      logic       sda;
      logic       busy;
      logic       done;
      logic       status;
      logic [7:0] rbyte;
   } line_step_type;

   // Line-step model of the engine plus the queue of predicted tick results.
   class line_step_scoreboard;
      line_step_type expected_steps[$];
      int          errors;
      int          results_seen;
      cmd_type     cmd;
      logic [2:0]  step;
      logic [2:0]  bit_idx;
      logic [7:0]  shift;
      logic [7:0]  poll_count;
      logic [7:0]  limit;
      logic        nack;
      logic        scl;
      logic        sda;

      function new();
         errors = 0;
         results_seen = 0;
         limit = 8'd10;
         cmd = CMD_IDLE;
         step = 3'd0;
         bit_idx = 3'd7;
         shift = 8'h00;
         poll_count = 8'h00;
         nack = 1'b0;
         scl = 1'b1;
         sda = 1'b1;
      endfunction

      function void set_limit(logic [7:0] value);
         limit = value;
      endfunction

      function bit is_busy();
         return cmd != CMD_IDLE;
      endfunction

      function bit polling_ack();
         return (cmd == CMD_WRITE || cmd == CMD_ADDR) && (step == 3'd5 || step == 3'd6);
      endfunction

      function int pending();
         return expected_steps.size();
      endfunction

      function void set_lines(logic c, logic d);
         scl = c;
         sda = d;
      endfunction

      function void end_command();
         cmd = CMD_IDLE;
         step = 3'd0;
         bit_idx = 3'd7;
         nack = 1'b0;
      endfunction

      // Advance the model by one accepted tick item and queue its result.
      function void predict_tick(op_type op, logic [7:0] data, logic last, logic sda_in);
         line_step_type r;
         logic       bit_val;
         r = '0;
         if (cmd == CMD_IDLE && op >= OP_START && op <= OP_STOP) begin
            cmd = op;
            step = 3'd0;
            bit_idx = 3'd7;
            poll_count = 8'h00;
            nack = 1'b0;
            if (op == OP_START || op == OP_WRITE) begin
               shift = data;
            end else if (op == OP_READ) begin
               shift = 8'h00;
               nack = last;
            end
         end
         bit_val = shift[bit_idx];
         case (cmd)
            CMD_START: begin
               case (step)
                  3'd0: set_lines(1'b0, 1'b1);
                  3'd1: set_lines(1'b1, 1'b1);
                  3'd2: set_lines(1'b1, 1'b0);
                  default: set_lines(1'b0, 1'b0);
               endcase
               if (step >= 3'd3) begin
                  cmd = CMD_ADDR;
                  step = 3'd0;
               end else begin
                  step = step + 3'd1;
               end
            end
            CMD_WRITE, CMD_ADDR: begin
               case (step)
                  3'd0: begin
                     set_lines(1'b0, 1'b0);
                     step = 3'd1;
                  end
                  3'd1: begin
                     set_lines(1'b0, bit_val);
                     step = 3'd2;
                  end
                  3'd2: begin
                     set_lines(1'b1, bit_val);
                     step = 3'd3;
                  end
                  3'd3: begin
                     set_lines(1'b0, bit_val);
                     if (bit_idx == 3'd0) begin
                        step = 3'd4;
                     end else begin
                        bit_idx = bit_idx - 3'd1;
                        step = 3'd1;
                     end
                  end
                  3'd4: begin
                     set_lines(1'b0, 1'b1);
                     step = 3'd5;
                  end
                  3'd5, 3'd6: begin
                     set_lines(1'b1, 1'b1);
                     if (step == 3'd5) poll_count = 8'h00;
                     if (!sda_in) begin
                        nack = 1'b0;
                        step = 3'd7;
                     end else if (poll_count >= limit) begin
                        nack = 1'b1;
                        step = 3'd7;
                     end else begin
                        poll_count = poll_count + 8'd1;
                        step = 3'd6;
                     end
                  end
                  default: begin
                     set_lines(1'b0, 1'b1);
                     // An unacknowledged address turns into a stop by itself.
                     if (cmd == CMD_ADDR && nack) begin
                        cmd = CMD_STOP;
                        step = 3'd0;
                     end else begin
                        r.done = 1'b1;
                        r.status = nack;
                        end_command();
                     end
                  end
               endcase
            end
            CMD_READ: begin
               case (step)
                  3'd0: begin
                     set_lines(1'b0, 1'b1);
                     step = 3'd1;
                  end
                  3'd1: begin
                     set_lines(1'b1, 1'b1);
                     if (sda_in) shift[bit_idx] = 1'b1;
                     step = 3'd2;
                  end
                  3'd2: begin
                     set_lines(1'b0, 1'b1);
                     if (bit_idx == 3'd0) begin
                        step = 3'd3;
                     end else begin
                        bit_idx = bit_idx - 3'd1;
                        step = 3'd1;
                     end
                  end
                  3'd3: begin
                     set_lines(1'b0, nack);
                     step = 3'd4;
                  end
                  3'd4: begin
                     set_lines(1'b1, nack);
                     step = 3'd5;
                  end
                  default: begin
                     set_lines(1'b0, nack);
                     r.done = 1'b1;
                     r.rbyte = shift;
                     end_command();
                  end
               endcase
            end
            CMD_STOP: begin
               if (step == 3'd0) begin
                  set_lines(1'b0, 1'b0);
                  step = 3'd1;
               end else if (step == 3'd1) begin
                  set_lines(1'b1, 1'b0);
                  step = 3'd2;
               end else begin
                  set_lines(1'b1, 1'b1);
                  r.done = 1'b1;
                  r.status = nack;
                  end_command();
               end
            end
            CMD_IDLE: ;
            default: end_command();
         endcase
         r.scl = scl;
         r.sda = sda;
         r.busy = (cmd != CMD_IDLE);
         expected_steps.push_back(r);
      endfunction

      task report(string msg);
         $display("ERROR at %0t: %s", $time, msg);
         errors++;
      endtask

      task check_result(line_step_type got);
         line_step_type exp;
         results_seen++;
         if (expected_steps.size() == 0) begin
            report($sformatf("result %0d arrived with no item outstanding", results_seen));
            return;
         end
         exp = expected_steps.pop_front();
         if (got.scl !== exp.scl)
            report($sformatf("result %0d scl_level %b, expected %b",
                             results_seen, got.scl, exp.scl));
         if (got.sda !== exp.sda)
            report($sformatf("result %0d sda_level %b, expected %b",
                             results_seen, got.sda, exp.sda));
         if (got.busy !== exp.busy)
            report($sformatf("result %0d busy_res %b, expected %b",
                             results_seen, got.busy, exp.busy));
         if (got.done !== exp.done)
            report($sformatf("result %0d done_res %b, expected %b",
                             results_seen, got.done, exp.done));
         if (got.status !== exp.status)
            report($sformatf("result %0d status %b, expected %b",
                             results_seen, got.status, exp.status));
         if (got.rbyte !== exp.rbyte)
            report($sformatf("result %0d read_byte %h, expected %h",
                             results_seen, got.rbyte, exp.rbyte));
      endtask
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   wire        req_stall;
   op_type     req_operation = OP_TICK;
   logic [7:0] req_data_byte = 8'h00;
   logic       req_last_byte = 1'b0;
   logic       req_sda_sample = 1'b1;
   wire        rsp_valid;
   logic       rsp_stall = 1'b0;
   wire        rsp_scl_level;
   wire        rsp_sda_level;
   wire        rsp_busy_res;
   wire        rsp_done_res;
   wire        rsp_status;
   wire  [7:0] rsp_read_byte;
   logic       csr_write_enable = 1'b0;
   logic [7:0] csr_write_data = 8'h00;

   line_step_scoreboard sb = new();
   bit quiet = 1'b0;
   int busy_items = 0;

   i2c_master_bit_engine dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_data_byte    (req_data_byte),
      .req_last_byte    (req_last_byte),
      .req_sda_sample   (req_sda_sample),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_scl_level    (rsp_scl_level),
      .rsp_sda_level    (rsp_sda_level),
      .rsp_busy_res     (rsp_busy_res),
      .rsp_done_res     (rsp_done_res),
      .rsp_status       (rsp_status),
      .rsp_read_byte    (rsp_read_byte),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Mostly no gap or a short one, now and then a long one; none at all in quiet phases.
   function automatic int pick_gap();
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 25);
   endfunction

   function automatic logic [7:0] pick_byte();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 8'h00;
      if (r == 1) return 8'hFF;
      return 8'($urandom_range(0, 255));
   endfunction

   // Number of polls answered with SDA high before the slave pulls it low.
   function automatic int pick_ack_delay();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return $urandom_range(0, 1);
      if (r < 70) return int'(sb.limit);
      if (r < 85) return $urandom_range(0, sb.limit);
      return 300;
   endfunction

   always @(posedge clock) begin : result_monitor
      line_step_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.scl = rsp_scl_level;
         got.sda = rsp_sda_level;
         got.busy = rsp_busy_res;
         got.done = rsp_done_res;
         got.status = rsp_status;
         got.rbyte = rsp_read_byte;
         sb.check_result(got);
      end
   end

   initial begin : stall_driver
      int n;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         n = pick_gap();
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
   end

   // Entered and left at a falling edge; the item is noted once accepted.
   task automatic send_item(op_type op, logic [7:0] data, logic last, logic sda_in);
      int gap;
      bit counted;
      gap = pick_gap();
      counted = sb.is_busy() || (op >= OP_START && op <= OP_STOP);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_data_byte <= data;
      req_last_byte <= last;
      req_sda_sample <= sda_in;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      sb.predict_tick(op, data, last, sda_in);
      if (counted) busy_items++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (sb.pending() != 0);
   endtask

   task automatic write_limit(logic [7:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      sb.set_limit(value);
   endtask

   // Tick until the command ends; noisy runs slip in commands while busy.
   task automatic finish_command(int ack_delay, bit noisy);
      int      polls;
      logic    s;
      op_type  op;
      polls = 0;
      while (sb.is_busy()) begin
         if (sb.polling_ack()) begin
            s = (polls >= ack_delay) ? 1'b0 : 1'b1;
            polls++;
         end else begin
            s = 1'($urandom_range(0, 1));
         end
         op = OP_TICK;
         if (noisy && $urandom_range(0, 19) == 0) op = op_type'($urandom_range(1, 7));
         send_item(op, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), s);
      end
   endtask

   task automatic run_command(op_type op, logic [7:0] data, logic last, int ack_delay,
                              bit noisy);
      send_item(op, data, last, 1'($urandom_range(0, 1)));
      finish_command(ack_delay, noisy);
   endtask

   task automatic random_transaction(bit noisy);
      int n;
      run_command(OP_START, pick_byte(), 1'($urandom_range(0, 1)), pick_ack_delay(), noisy);
      n = $urandom_range(0, 3);
      repeat (n) begin
         if ($urandom_range(0, 1))
            run_command(OP_WRITE, pick_byte(), 1'($urandom_range(0, 1)), pick_ack_delay(),
                        noisy);
         else
            run_command(OP_READ, pick_byte(), 1'($urandom_range(0, 1)), 0, noisy);
      end
      run_command(OP_STOP, pick_byte(), 1'($urandom_range(0, 1)), 0, noisy);
   endtask

   // Stray items of any code, then whatever they started is run to its end.
   task automatic noise_burst();
      repeat ($urandom_range(1, 4))
         send_item(op_type'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      finish_command(pick_ack_delay(), 1'b1);
   endtask

   initial begin : stimulus
      int guard;
      logic [7:0] phase_limit;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Idle tick and undefined codes while idle: nothing may move.
      send_item(OP_TICK, 8'hFF, 1'b1, 1'b1);
      for (int k = 1; k <= 3; k++)
         send_item(op_type'(OP_STOP + k), 8'hFF, 1'b1, 1'b0);
      // Address acknowledged on the first poll.
      run_command(OP_START, 8'h00, 1'b0, 0, 1'b0);
      // Write acknowledged on the very last poll, with commands sent while busy.
      send_item(OP_WRITE, 8'hFF, 1'b0, 1'b1);
      send_item(OP_START, 8'h00, 1'b1, 1'b0);
      send_item(OP_READ, 8'h55, 1'b1, 1'b1);
      finish_command(10, 1'b0);
      run_command(OP_READ, 8'h00, 1'b0, 0, 1'b0);
      run_command(OP_READ, 8'hFF, 1'b1, 0, 1'b0);
      run_command(OP_STOP, 8'h00, 1'b0, 0, 1'b0);
      // Unacknowledged address runs its own stop and reports no acknowledge.
      run_command(OP_START, 8'hA5, 1'b0, 300, 1'b0);
      // Unacknowledged write outside any start.
      run_command(OP_WRITE, 8'h3C, 1'b0, 300, 1'b0);
      // Limit lowered while polling: the next poll ends the wait at once.
      send_item(OP_WRITE, 8'h5A, 1'b0, 1'b1);
      while (!(sb.polling_ack() && sb.poll_count >= 8'd5))
         send_item(OP_TICK, 8'h00, 1'b0, 1'b1);
      drain();
      write_limit(8'd2);
      finish_command(300, 1'b0);
      // A zero limit allows a single poll.
      drain();
      write_limit(8'd0);
      run_command(OP_START, 8'hFF, 1'b0, 300, 1'b0);
      run_command(OP_WRITE, 8'h81, 1'b0, 0, 1'b0);

      for (int p = 0; p < 6; p++) begin
         drain();
         case (p)
            0: phase_limit = 8'd0;
            1: phase_limit = 8'd255;
            2: phase_limit = 8'd1;
            4: phase_limit = 8'd10;
            default: phase_limit = 8'($urandom_range(0, 40));
         endcase
         write_limit(phase_limit);
         quiet = (p == 3);
         busy_items = 0;
         while (busy_items < 90) begin
            if ($urandom_range(0, 4) == 0) noise_burst();
            else random_transaction($urandom_range(0, 3) == 0);
         end
      end

      req_valid <= 1'b0;
      guard = 0;
      while (sb.pending() != 0 && guard < 20000) begin
         @(negedge clock);
         guard++;
      end
      repeat (4) @(negedge clock);
      if (sb.pending() != 0)
         sb.report($sformatf("%0d results never arrived", sb.pending()));
      if (sb.errors == 0) begin
         $display("i2c_master_bit_engine verification clean");
      end else begin
         $display("i2c_master_bit_engine verification failed");
      end
      $finish;
   end

   initial begin : watchdog
      #4000000;
      $display("ERROR: run did not finish in time");
      $display("i2c_master_bit_engine verification failed");
      $finish;
   end

endmodule
